// ===== rtl/core/edfq_pkg.sv =====
// edfq_pkg: shared constants, codes and types of the EDF ready queue.
// Used by edfq_cell and edf_deadline_ready_queue.
// No dependencies.
package edfq_pkg;

   // default sizes, handed down through top-level parameters
   localparam int DEPTH_DEF     = 16;
   localparam int ID_BITS_DEF   = 8;
   localparam int TIME_BITS_DEF = 32;

   // fixed request and result field widths
   localparam int STATUS_W = 3;
   localparam int RANK_W   = 4;
   localparam int COUNT_W  = 5;
   localparam int MODE_W   = 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CAP_W      = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = 1'b0;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd4;

   // cell commands
   localparam logic [2:0] CELL_HOLD    = 3'd0;
   localparam logic [2:0] CELL_EVAL_LE = 3'd1;
   localparam logic [2:0] CELL_EVAL_LT = 3'd2;
   localparam logic [2:0] CELL_EVAL_ID = 3'd3;
   localparam logic [2:0] CELL_INSERT  = 3'd4;
   localparam logic [2:0] CELL_DROP    = 3'd5;

   // per-cell control from the sequencer
   typedef struct packed {
      logic [2:0] op;        // command for this cycle
      logic       occ;       // cell lies below the task count
      logic       left_hit;  // left neighbour holds a deadline <= new one
      logic       drop_sel;  // cell takes its right neighbour on a drop
   } cell_ctl_type;

endpackage

// ===== rtl/core/edfq_cell.sv =====
// edfq_cell: one slot of the sorted row; holds an id, a deadline and a hit flag.
// Shifts data in from its left (insert) or right (drop) neighbour.
// Depends on edfq_pkg.
module edfq_cell #(
   parameter int ID_BITS   = edfq_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = edfq_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  edfq_pkg::cell_ctl_type ctl,
   input  logic [ID_BITS-1:0]   key_id,
   input  logic [TIME_BITS-1:0] key_dl,
   input  logic [ID_BITS-1:0]   left_id,
   input  logic [TIME_BITS-1:0] left_dl,
   input  logic [ID_BITS-1:0]   right_id,
   input  logic [TIME_BITS-1:0] right_dl,
   input  logic                 right_hit,
   output logic [ID_BITS-1:0]   slot_id,
   output logic [TIME_BITS-1:0] slot_dl,
   output logic                 hit
);

   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [TIME_BITS-1:0] dl_ff, dl_in;
   logic                 hit_ff, hit_in;
   logic                 my_hit;

   // next slot contents
   always_comb begin
      id_in  = id_ff;
      dl_in  = dl_ff;
      hit_in = hit_ff;
      my_hit = hit_ff & ctl.occ;
      case (ctl.op)
         edfq_pkg::CELL_EVAL_LE: hit_in = (dl_ff <= key_dl);
         edfq_pkg::CELL_EVAL_LT: hit_in = (dl_ff < key_dl);
         edfq_pkg::CELL_EVAL_ID: hit_in = (id_ff == key_id);
         edfq_pkg::CELL_INSERT: begin
            if (!ctl.left_hit) begin
               // right of the insertion point: move one place on
               id_in = left_id;
               dl_in = left_dl;
            end else if (!my_hit) begin
               // the insertion point itself
               id_in = key_id;
               dl_in = key_dl;
            end
         end
         edfq_pkg::CELL_DROP: begin
            if (ctl.drop_sel) begin
               id_in  = right_id;
               dl_in  = right_dl;
               hit_in = right_hit;
            end
         end
         default: ;
      endcase
   end

   // slot registers, payload only
   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      dl_ff  <= dl_in;
      hit_ff <= hit_in;
   end

   assign slot_id = id_ff;
   assign slot_dl = dl_ff;
   assign hit     = hit_ff;

endmodule

// ===== rtl/core/edfq_prefix_or.sv =====
// edfq_prefix_or: log-depth inclusive prefix OR over the cell hit flags.
// Finds everything at and after the first matching cell.
// Depends on nothing.
module edfq_prefix_or #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0] vec_in,
   output logic [WIDTH-1:0] prefix_out
);

   localparam int LEVELS = $clog2(WIDTH);

   logic [WIDTH-1:0] lvl [LEVELS+1];

   assign lvl[0] = vec_in;

   // each level folds in the span 2**k below
   for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
      assign lvl[k+1] = lvl[k] | (lvl[k] << (2 ** k));
   end

   assign prefix_out = lvl[LEVELS];

endmodule

// ===== rtl/core/edf_deadline_ready_queue.sv =====
// edf_deadline_ready_queue: EDF ready queue, a row of DEPTH sorted cells and
// a small sequencer. Depends on edfq_pkg, edfq_cell and edfq_prefix_or.
//
//  channel | direction | handshake           | words
//  req_    | in        | req_valid/req_stall | mode, task_id, deadline, now_tick
//  rsp_    | out       | rsp_valid/rsp_stall | status, id, deadline, rank, count, last
//  csr     | in/out    | APB, pready tied 1  | capacity_limit at byte address 0
//
// Insert, remove and pop: the word is taken in idle, compared in eval and its result
// registered in apply; no new word is taken until the sequencer is back in idle. Expire:
// one result per shift of the cell row, all reported from apply before returning to idle.
// Reset (synchronous) empties the queue and sets capacity_limit to 16; no clearing pass.
// rsp_stall with a result pending holds the sequencer and the cell row in the apply step.
module edf_deadline_ready_queue #(
   parameter int DEPTH     = edfq_pkg::DEPTH_DEF,
   parameter int ID_BITS   = edfq_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = edfq_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [edfq_pkg::MODE_W-1:0]       req_mode,
   input  logic [ID_BITS-1:0]                req_task_id,
   input  logic [TIME_BITS-1:0]              req_deadline,
   input  logic [TIME_BITS-1:0]              req_now_tick,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [edfq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ID_BITS-1:0]                rsp_task_id_out,
   output logic [TIME_BITS-1:0]              rsp_deadline_out,
   output logic [edfq_pkg::RANK_W-1:0]       rsp_rank,
   output logic [edfq_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_last,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [edfq_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [edfq_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [edfq_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LIM_W = (CNT_W > edfq_pkg::CAP_W) ? CNT_W : edfq_pkg::CAP_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   // ---------------- configuration ----------------
   logic [edfq_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                       reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[edfq_pkg::CSR_ADDR_W-1:2] == edfq_pkg::REG_CAPACITY);

   always_comb begin
      cap_in = cap_ff;
      if (psel && penable && pwrite && reg_sel) begin
         cap_in = pwdata[edfq_pkg::CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = edfq_pkg::CSR_DATA_W'(cap_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= edfq_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // ---------------- sequencer state ----------------
   logic [1:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            n_ff, n_in;
   logic [edfq_pkg::MODE_W-1:0] mode_ff;
   logic [ID_BITS-1:0]          id_ff;
   logic [TIME_BITS-1:0]        dl_ff, now_ff;
   logic                        req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // captured request word
   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         id_ff   <= req_task_id;
         dl_ff   <= req_deadline;
         now_ff  <= req_now_tick;
      end
   end

   // ---------------- cell row ----------------
   logic [ID_BITS-1:0]     c_id [DEPTH];
   logic [TIME_BITS-1:0]   c_dl [DEPTH];
   logic [DEPTH-1:0]       c_hit;
   logic [ID_BITS-1:0]     l_id [DEPTH];
   logic [TIME_BITS-1:0]   l_dl [DEPTH];
   logic [ID_BITS-1:0]     r_id [DEPTH];
   logic [TIME_BITS-1:0]   r_dl [DEPTH];
   logic [DEPTH-1:0]       r_hit;
   logic [DEPTH-1:0]       occ, hit_g, after_hit, first_hit, ins_pt, sel_vec;
   logic [2:0]             cell_op;
   logic [TIME_BITS-1:0]   key_dl;
   edfq_pkg::cell_ctl_type ctl [DEPTH];

   assign key_dl = (mode_ff == edfq_pkg::MODE_EXPIRE) ? now_ff : dl_ff;

   // occupancy and neighbour wiring
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i] = (CNT_W'(i) < count_ff);
      end
      hit_g = c_hit & occ;
      l_id[0] = id_ff;
      l_dl[0] = dl_ff;
      for (int i = 1; i < DEPTH; i++) begin
         l_id[i] = c_id[i-1];
         l_dl[i] = c_dl[i-1];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
         r_id[i]  = c_id[i+1];
         r_dl[i]  = c_dl[i+1];
         r_hit[i] = c_hit[i+1];
      end
      r_id[DEPTH-1]  = c_id[DEPTH-1];
      r_dl[DEPTH-1]  = c_dl[DEPTH-1];
      r_hit[DEPTH-1] = c_hit[DEPTH-1];
   end

   // first id match and everything after it
   edfq_prefix_or #(
      .WIDTH (DEPTH)
   ) u_prefix (
      .vec_in     (hit_g),
      .prefix_out (after_hit)
   );

   assign first_hit = hit_g & ~(after_hit << 1);
   assign ins_pt    = ~hit_g & {hit_g[DEPTH-2:0], 1'b1};
   assign sel_vec   = (mode_ff == edfq_pkg::MODE_INSERT) ? ins_pt : first_hit;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctl[i].op       = cell_op;
      assign ctl[i].occ      = occ[i];
      assign ctl[i].left_hit = (i == 0) ? 1'b1 : hit_g[(i == 0) ? 0 : i - 1];
      assign ctl[i].drop_sel = (mode_ff == edfq_pkg::MODE_REMOVE) ? after_hit[i] : 1'b1;

      edfq_cell #(
         .ID_BITS   (ID_BITS),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl[i]),
         .key_id    (id_ff),
         .key_dl    (key_dl),
         .left_id   (l_id[i]),
         .left_dl   (l_dl[i]),
         .right_id  (r_id[i]),
         .right_dl  (r_dl[i]),
         .right_hit (r_hit[i]),
         .slot_id   (c_id[i]),
         .slot_dl   (c_dl[i]),
         .hit       (c_hit[i])
      );
   end

   // encode the selected cell: position and deadline
   logic [IDX_W-1:0]     sel_idx;
   logic [TIME_BITS-1:0] sel_dl;

   always_comb begin
      sel_idx = '0;
      sel_dl  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (sel_vec[i]) begin
            sel_idx = sel_idx | IDX_W'(i);
            sel_dl  = sel_dl | c_dl[i];
         end
      end
   end

   // capacity check
   logic [LIM_W-1:0] limit;
   logic             full;

   assign limit = (LIM_W'(cap_ff) < LIM_W'(DEPTH)) ? LIM_W'(cap_ff) : LIM_W'(DEPTH);
   assign full  = (LIM_W'(count_ff) >= limit);

   // ---------------- sequencer and result word ----------------
   logic                          out_free, out_load;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [edfq_pkg::STATUS_W-1:0] o_status;
   logic [ID_BITS-1:0]            o_id;
   logic [TIME_BITS-1:0]          o_dl;
   logic [IDX_W-1:0]              o_rank;
   logic                          o_last;
   logic [edfq_pkg::STATUS_W-1:0] status_ff;
   logic [ID_BITS-1:0]            oid_ff;
   logic [TIME_BITS-1:0]          odl_ff;
   logic [edfq_pkg::RANK_W-1:0]   rank_ff;
   logic [edfq_pkg::COUNT_W-1:0]  ocount_ff;
   logic                          last_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cell_op  = edfq_pkg::CELL_HOLD;
      out_load = 1'b0;
      o_status = edfq_pkg::ST_OK;
      o_id     = id_ff;
      o_dl     = dl_ff;
      o_rank   = '0;
      o_last   = 1'b1;
      count_in = count_ff;
      state_in = state_ff;
      n_in     = n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EVAL;
               n_in     = '0;
            end
         end
         ST_EVAL: begin
            // every cell compares against the key at once
            case (mode_ff)
               edfq_pkg::MODE_INSERT: cell_op = edfq_pkg::CELL_EVAL_LE;
               edfq_pkg::MODE_REMOVE: cell_op = edfq_pkg::CELL_EVAL_ID;
               edfq_pkg::MODE_EXPIRE: cell_op = edfq_pkg::CELL_EVAL_LT;
               default:               cell_op = edfq_pkg::CELL_HOLD;
            endcase
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
               case (mode_ff)
                  edfq_pkg::MODE_INSERT: begin
                     if (full) begin
                        o_status = edfq_pkg::ST_FULL;
                     end else begin
                        cell_op  = edfq_pkg::CELL_INSERT;
                        count_in = count_ff + 1'b1;
                        o_rank   = sel_idx;
                     end
                  end
                  edfq_pkg::MODE_REMOVE: begin
                     if (|hit_g) begin
                        cell_op  = edfq_pkg::CELL_DROP;
                        count_in = count_ff - 1'b1;
                        o_dl     = sel_dl;
                        o_rank   = sel_idx;
                     end else begin
                        o_status = edfq_pkg::ST_NOTFOUND;
                        o_dl     = '0;
                     end
                  end
                  edfq_pkg::MODE_POP: begin
                     if (count_ff == '0) begin
                        o_status = edfq_pkg::ST_EMPTY;
                        o_id     = '0;
                        o_dl     = '0;
                     end else begin
                        cell_op  = edfq_pkg::CELL_DROP;
                        count_in = count_ff - 1'b1;
                        o_id     = c_id[0];
                        o_dl     = c_dl[0];
                     end
                  end
                  edfq_pkg::MODE_EXPIRE: begin
                     if (hit_g[0]) begin
                        // head is overdue: report it and shift the row
                        cell_op  = edfq_pkg::CELL_DROP;
                        count_in = count_ff - 1'b1;
                        o_id     = c_id[0];
                        o_dl     = c_dl[0];
                        o_rank   = n_ff;
                        o_last   = !hit_g[1];
                        n_in     = n_ff + 1'b1;
                        if (hit_g[1]) begin
                           state_in = ST_APPLY;
                        end
                     end else begin
                        o_status = edfq_pkg::ST_NOTHING;
                        o_id     = '0;
                        o_dl     = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff <= o_status;
         oid_ff    <= o_id;
         odl_ff    <= o_dl;
         rank_ff   <= edfq_pkg::RANK_W'(o_rank);
         ocount_ff <= edfq_pkg::COUNT_W'(count_in);
         last_ff   <= o_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_task_id_out  = oid_ff;
   assign rsp_deadline_out = odl_ff;
   assign rsp_rank         = rank_ff;
   assign rsp_count        = ocount_ff;
   assign rsp_last         = last_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("task count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + 1'b1 ||
                         count_ff == $past(count_ff) - 1'b1))
      else $error("task count moved by more than one");

   a_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && (mode_ff == edfq_pkg::MODE_INSERT ||
                                mode_ff == edfq_pkg::MODE_EXPIRE))
      |-> ((hit_g & (hit_g + 1'b1)) == '0))
      else $error("deadline compare flags not a prefix, row out of order");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_APPLY)
      else $error("result word loaded outside the apply step");

endmodule
